// ----- hw/rtl/fba_pkg.sv -----
// ----------------------------------------------------------------------------
// Free-list allocator package
// Beat types, status codes, controller states and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int unsigned CNT_W = 11;
    localparam int unsigned IDX_W = 10;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CNT_W-1:0] INIT_BLOCKS_RESET = 11'd64;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OOM   = 2'd1,
        ST_RANGE = 2'd2,
        ST_NULL  = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } func_t;

    typedef struct packed {
        logic             func;
        logic             block_present;
        logic [IDX_W-1:0] block_index;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        status_t          status;
        logic [CNT_W-1:0] used_count;
        logic [CNT_W-1:0] free_count;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GROW,
        S_EXEC
    } fsm_state_t;

    typedef struct packed {
        logic    latch_req;
        logic    load_build;
        logic    load_grow;
        logic    grow_step;
        logic    alloc_pop;
        logic    free_push;
        logic    emit;
        status_t status;
    } fba_cmd_t;

    typedef struct packed {
        logic pool_built;
        logic head_null;
        logic cnt_zero;
        logic func;
        logic present;
        logic in_range;
    } fba_sts_t;

endpackage

// ----- hw/rtl/fba_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module fba_ram #(
    parameter int unsigned WIDTH = 11,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/fba_ctrl.sv -----
// ----------------------------------------------------------------------------
// Free-list allocator controller
// Sequences pool building, growth, allocate and free, and decides the status
// of each result.
// ----------------------------------------------------------------------------
module fba_ctrl
    import fba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  fba_sts_t sts,
    output fba_cmd_t cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       tried_reg;
    logic       tried_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tried_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tried_reg <= tried_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        tried_next = tried_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        busy       = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch_req = 1'b1;
                    tried_next    = 1'b0;
                    if (!sts.pool_built)
                    begin
                        cmd.load_build = 1'b1;
                        state_next     = S_GROW;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_GROW:
            begin
                if (sts.cnt_zero)
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    cmd.grow_step = 1'b1;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                cmd.emit   = 1'b1;
                if (sts.func == FN_ALLOC)
                begin
                    if (sts.head_null)
                    begin
                        if (!tried_reg)
                        begin
                            cmd.emit      = 1'b0;
                            cmd.load_grow = 1'b1;
                            tried_next    = 1'b1;
                            state_next    = S_GROW;
                        end
                        else
                        begin
                            cmd.status = ST_OOM;
                        end
                    end
                    else
                    begin
                        cmd.alloc_pop = 1'b1;
                    end
                end
                else if (!sts.present)
                begin
                    cmd.status = ST_NULL;
                end
                else if (!sts.in_range)
                begin
                    cmd.status = ST_RANGE;
                end
                else
                begin
                    cmd.free_push = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/fba_dp.sv -----
// ----------------------------------------------------------------------------
// Free-list allocator datapath
// Holds the list head, grown region, counts and the next-link memory, and
// forms the result beat.
// ----------------------------------------------------------------------------
module fba_dp
    import fba_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = 1024,
    parameter int unsigned GROW_STEP  = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  req_t             req,
    input  logic             cfg_valid,
    input  logic [CNT_W-1:0] cfg_data,
    input  fba_cmd_t         cmd,
    output fba_sts_t         sts,
    output rsp_t             rsp,
    output logic             done
);

    localparam int unsigned AW = $clog2(MAX_BLOCKS);
    localparam int unsigned PW = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned GW = $clog2(GROW_STEP + 1);
    localparam int unsigned CW = (PW > IDX_W) ? PW : IDX_W;
    localparam int unsigned NW0 = (PW > CNT_W) ? PW : CNT_W;
    localparam int unsigned NW = (NW0 > GW) ? NW0 : GW;
    localparam logic [PW-1:0] NULL_PTR = PW'(MAX_BLOCKS);

    req_t             req_reg;
    logic [CNT_W-1:0] init_reg;
    logic             built_reg;
    logic [PW-1:0]    head_reg;
    logic [PW-1:0]    head_next;
    logic [PW-1:0]    grown_reg;
    logic [PW-1:0]    grown_next;
    logic [PW-1:0]    cnt_reg;
    logic [PW-1:0]    cnt_next;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] used_next;
    logic [CNT_W-1:0] free_reg;
    logic [CNT_W-1:0] free_next;
    rsp_t             rsp_reg;
    logic             done_reg;

    logic [CW-1:0]    bidx_ext;
    logic [CW-1:0]    head_ext;
    logic [NW-1:0]    init_ext;
    logic [NW-1:0]    room;
    logic [NW-1:0]    build_n;
    logic [NW-1:0]    grow_n;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [PW-1:0]    link_rd;

    assign bidx_ext = CW'(req_reg.block_index);
    assign head_ext = CW'(head_reg);
    assign init_ext = NW'(init_reg);
    assign room     = NW'(MAX_BLOCKS) - NW'(grown_reg);
    assign build_n  = (init_ext > NW'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS) : init_ext;
    assign grow_n   = (room < NW'(GROW_STEP)) ? room : NW'(GROW_STEP);

    assign sts.pool_built = built_reg;
    assign sts.head_null  = (head_reg == NULL_PTR);
    assign sts.cnt_zero   = (cnt_reg == '0);
    assign sts.func       = req_reg.func;
    assign sts.present    = req_reg.block_present;
    assign sts.in_range   = (bidx_ext < CW'(grown_reg));

    assign we    = cmd.grow_step || cmd.free_push;
    assign waddr = cmd.grow_step ? grown_reg[AW-1:0] : bidx_ext[AW-1:0];

    fba_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (head_reg),
        .raddr (head_reg[AW-1:0]),
        .rdata (link_rd)
    );

    always_comb
    begin
        head_next  = head_reg;
        grown_next = grown_reg;
        cnt_next   = cnt_reg;
        used_next  = used_reg;
        free_next  = free_reg;
        if (cmd.load_build)
        begin
            cnt_next = build_n[PW-1:0];
        end
        if (cmd.load_grow)
        begin
            cnt_next = grow_n[PW-1:0];
        end
        if (cmd.grow_step)
        begin
            head_next  = grown_reg;
            grown_next = grown_reg + 1'b1;
            cnt_next   = cnt_reg - 1'b1;
            if (free_reg != COUNT_MAX)
            begin
                free_next = free_reg + 1'b1;
            end
        end
        if (cmd.alloc_pop)
        begin
            head_next = link_rd;
            if (used_reg != COUNT_MAX)
            begin
                used_next = used_reg + 1'b1;
            end
            if (free_reg != '0)
            begin
                free_next = free_reg - 1'b1;
            end
        end
        if (cmd.free_push)
        begin
            head_next = bidx_ext[PW-1:0];
            if (used_reg != '0)
            begin
                used_next = used_reg - 1'b1;
            end
            if (free_reg != COUNT_MAX)
            begin
                free_next = free_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg  <= INIT_BLOCKS_RESET;
            built_reg <= 1'b0;
            head_reg  <= NULL_PTR;
            grown_reg <= '0;
            cnt_reg   <= '0;
            used_reg  <= '0;
            free_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                init_reg <= cfg_data;
            end
            if (cmd.load_build)
            begin
                built_reg <= 1'b1;
            end
            head_reg  <= head_next;
            grown_reg <= grown_next;
            cnt_reg   <= cnt_next;
            used_reg  <= used_next;
            free_reg  <= free_next;
            done_reg  <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_reg <= req;
        end
        if (cmd.emit)
        begin
            rsp_reg.granted_index <= cmd.alloc_pop ? head_ext[IDX_W-1:0] : '0;
            rsp_reg.status        <= cmd.status;
            rsp_reg.used_count    <= used_next;
            rsp_reg.free_count    <= free_next;
        end
    end

    assign rsp  = rsp_reg;
    assign done = done_reg;

endmodule

// ----- hw/rtl/fixed_block_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// Fixed-size block free-list allocator
// Allocate pops and free pushes block indices on a LIFO list kept in a
// next-link RAM; the pool is built on the first command and grown on demand.
// Allocate and free go from idle to S_EXEC, and the result beat is registered
// into done and rsp; busy holds until idle, so a new command waits for the
// last. The first command builds the pool in S_GROW, and an empty allocate
// grows it there once. Reset clears control and counts, not the RAM.
// The receiver cannot stall: done is high for exactly one cycle per command.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator
    import fba_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = 1024,
    parameter int unsigned GROW_STEP  = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             req,
    output logic             done,
    output rsp_t             rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    fba_cmd_t cmd;
    fba_sts_t sts;

    assign cfg_ready = 1'b1;

    fba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    fba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .GROW_STEP  (GROW_STEP)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp),
        .done      (done)
    );

endmodule

// ----- hw/rtl/fba_checker.sv -----
// ----------------------------------------------------------------------------
// Free-list allocator checker
// Port-level properties of the command and result beats, bound to the top.
// ----------------------------------------------------------------------------
module fba_checker
    import fba_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    a_done_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Result beat shown while a command is in progress.");

    a_done_single : assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result beats on two consecutive cycles.");

    a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("Command accepted but the block did not go busy.");

    a_grant_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_OK) |-> (rsp.granted_index == '0))
        else $error("Granted index non-zero on a failed command.");

endmodule

bind fixed_block_free_list_allocator fba_checker u_fba_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
